// ----- sv/drpf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// drpf_pkg: shared types and constants of the DMA region permission filter
// Payload structs, operation codes, window field widths and queue sizing.
// ----------------------------------------------------------------------------
package drpf_pkg;

   // Field widths
   localparam int ADDR_BITS       = 42;
   localparam int PAGE_SHIFT      = 12;
   localparam int PAGE_BITS       = ADDR_BITS - PAGE_SHIFT;
   localparam int WORD_BITS       = 32;
   localparam int INDEX_BITS      = 6;
   localparam int MODE_BITS       = 2;
   localparam int VERSION_BITS    = 2;

   // Register file organisation: four banks of sixteen words
   localparam int BANK_WORDS      = 16;
   localparam int BANK_INDEX_BITS = 4;
   localparam int BANK_SEL_BITS   = INDEX_BITS - BANK_INDEX_BITS;

   localparam logic [BANK_SEL_BITS-1:0] BANK_LAYOUT = 2'd0;
   localparam logic [BANK_SEL_BITS-1:0] BANK_START  = 2'd1;
   localparam logic [BANK_SEL_BITS-1:0] BANK_SIZE   = 2'd2;
   localparam logic [BANK_SEL_BITS-1:0] BANK_SPARE  = 2'd3;

   // Window field widths per layout version
   localparam int START_SHORT_BITS = 24;
   localparam int START_LONG_BITS  = 30;
   localparam int SIZE_V1_BITS     = 19;
   localparam int SIZE_V2_BITS     = 24;
   localparam int SIZE_V3_BITS     = 30;

   localparam logic [PAGE_SHIFT-1:0] PAGE_OFFSET_MASK = 12'hFFF;

   // Parameter defaults
   localparam int DEF_NUM_WINDOWS = 16;
   localparam int DEF_REG_WORDS   = 64;
   localparam int DEF_VA_BITS     = 42;

   // Queue between front and back; depth is a power of two
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);

   // Request modes
   localparam logic [MODE_BITS-1:0] MODE_WRITE = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_CHECK = 2'd2;

   // Layout versions
   localparam logic [VERSION_BITS-1:0] VERSION_NONE  = 2'd0;
   localparam logic [VERSION_BITS-1:0] VERSION_1     = 2'd1;
   localparam logic [VERSION_BITS-1:0] VERSION_2     = 2'd2;
   localparam logic [VERSION_BITS-1:0] VERSION_3     = 2'd3;
   localparam logic [VERSION_BITS-1:0] VERSION_RESET = VERSION_2;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_CHECK = 2'd3
   } op_type;

   typedef struct packed {
      logic [MODE_BITS-1:0]  mode;
      logic [INDEX_BITS-1:0] register_index;
      logic [WORD_BITS-1:0]  write_data;
      logic [ADDR_BITS-1:0]  dma_address;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]  read_data;
      logic                  access_allowed;
      logic [ADDR_BITS-1:0]  page_address;
   } rsp_type;

   // Classified operation held in the queue
   typedef struct packed {
      op_type                op;
      logic [INDEX_BITS-1:0] index;
      logic [WORD_BITS-1:0]  data;
      logic [ADDR_BITS-1:0]  page_address;
   } entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

endpackage
`default_nettype wire

// ----- sv/drpf_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// drpf_front: request intake and classification
// Accepts requests, drops out-of-range register accesses, masks and aligns
// the DMA address, and pushes the classified operation into the queue.
// ----------------------------------------------------------------------------
module drpf_front
   import drpf_pkg::*;
#(
   parameter int REG_WORDS = DEF_REG_WORDS,
   parameter int VA_BITS   = DEF_VA_BITS
) (
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_type      req_data,
   input  wire q_status_type q_status,
   output logic              push,
   output entry_type         push_entry
);

   localparam int KEEP_BITS = (VA_BITS < ADDR_BITS) ? VA_BITS : ADDR_BITS;
   localparam logic [ADDR_BITS-1:0] VA_MASK =
      {ADDR_BITS{1'b1}} >> (ADDR_BITS - KEEP_BITS);
   localparam logic [ADDR_BITS-1:0] OFFSET_MASK = ADDR_BITS'(PAGE_OFFSET_MASK);

   logic in_range;

   // Hold the requester off while the queue is full
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   assign in_range = (32'(req_data.register_index) < REG_WORDS);

   // Classify the transfer
   always_comb begin
      push_entry              = '0;
      push_entry.index        = req_data.register_index;
      push_entry.data         = req_data.write_data;
      push_entry.page_address = req_data.dma_address & VA_MASK & ~OFFSET_MASK;
      case (req_data.mode)
         MODE_WRITE: begin
            push_entry.op = in_range ? OP_WRITE : OP_NONE;
         end
         MODE_READ: begin
            push_entry.op = in_range ? OP_READ : OP_NONE;
         end
         MODE_CHECK: begin
            push_entry.op = OP_CHECK;
         end
         default: begin
            push_entry.op = OP_NONE;
         end
      endcase
      if (push_entry.op != OP_CHECK) begin
         push_entry.page_address = '0;
      end
   end

endmodule
`default_nettype wire

// ----- sv/drpf_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// drpf_queue: short FIFO between front and back
// Holds classified operations so intake and execution stall independently.
// ----------------------------------------------------------------------------
module drpf_queue
   import drpf_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   input  wire logic      pop,
   output entry_type      pop_entry,
   output q_status_type   status
);

   entry_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;

   assign pop_entry        = slot_ff[rd_ptr_ff];
   assign status.full      = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ----- sv/drpf_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// drpf_back: register file, window check and result register
// Executes queued operations in order: stores and reads register words,
// checks a page against every window in parallel and registers the result.
// ----------------------------------------------------------------------------
module drpf_back
   import drpf_pkg::*;
#(
   parameter int NUM_WINDOWS = DEF_NUM_WINDOWS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire q_status_type            q_status,
   input  wire entry_type               q_entry,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output rsp_type                      rsp_data,
   input  wire logic                    csr_write_enable,
   input  wire logic [VERSION_BITS-1:0] csr_write_data
);

   logic [WORD_BITS-1:0]       layout_ff [BANK_WORDS];
   logic [WORD_BITS-1:0]       start_ff  [BANK_WORDS];
   logic [WORD_BITS-1:0]       size_ff   [BANK_WORDS];
   logic [WORD_BITS-1:0]       spare_ff  [BANK_WORDS];
   logic [VERSION_BITS-1:0]    version_ff, version_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;
   logic [WORD_BITS-1:0]       wr_word_in;
   logic [BANK_SEL_BITS-1:0]   bank_sel;
   logic [BANK_INDEX_BITS-1:0] bank_idx;
   logic [WORD_BITS-1:0]       read_word;
   logic [PAGE_BITS-1:0]       page;
   logic [NUM_WINDOWS-1:0]     hit;

   assign bank_sel   = q_entry.index[INDEX_BITS-1:BANK_INDEX_BITS];
   assign bank_idx   = q_entry.index[BANK_INDEX_BITS-1:0];
   assign page       = q_entry.page_address[ADDR_BITS-1:PAGE_SHIFT];
   assign wr_word_in = q_entry.data;

   // Take an entry whenever the result register is free or being drained
   assign pop = q_status.not_empty && (!rsp_valid_ff || !rsp_stall);

   // Layout version register
   assign version_in = csr_write_enable ? csr_write_data : version_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VERSION_RESET;
      end else begin
         version_ff <= version_in;
      end
   end

   // Store register words; the front has already dropped out-of-range writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BANK_WORDS; i++) begin
            layout_ff[i] <= '0;
            start_ff[i]  <= '0;
            size_ff[i]   <= '0;
            spare_ff[i]  <= '0;
         end
      end else if (pop && q_entry.op == OP_WRITE) begin
         case (bank_sel)
            BANK_LAYOUT: layout_ff[bank_idx] <= wr_word_in;
            BANK_START:  start_ff[bank_idx]  <= wr_word_in;
            BANK_SIZE:   size_ff[bank_idx]   <= wr_word_in;
            BANK_SPARE:  spare_ff[bank_idx]  <= wr_word_in;
            default:     ;
         endcase
      end
   end

   // Select the addressed word for a read
   always_comb begin
      case (bank_sel)
         BANK_LAYOUT: read_word = layout_ff[bank_idx];
         BANK_START:  read_word = start_ff[bank_idx];
         BANK_SIZE:   read_word = size_ff[bank_idx];
         BANK_SPARE:  read_word = spare_ff[bank_idx];
         default:     read_word = '0;
      endcase
   end

   // Decode each window for the current version and compare the page
   for (genvar w = 0; w < NUM_WINDOWS; w++) begin : g_window
      logic [PAGE_BITS-1:0] start_w;
      logic [PAGE_BITS-1:0] size_w;
      logic                 on_w;
      logic [PAGE_BITS:0]   limit_w;

      always_comb begin
         start_w = '0;
         size_w  = '0;
         on_w    = 1'b0;
         case (version_ff)
            VERSION_1: begin
               start_w = PAGE_BITS'(start_ff[w][START_SHORT_BITS-1:0]);
               size_w  = PAGE_BITS'(layout_ff[w][SIZE_V1_BITS-1:0]);
               on_w    = |layout_ff[w][WORD_BITS-1:SIZE_V1_BITS];
            end
            VERSION_2: begin
               start_w = PAGE_BITS'(start_ff[w][START_SHORT_BITS-1:0]);
               size_w  = PAGE_BITS'(layout_ff[w][SIZE_V2_BITS-1:0]);
               on_w    = |layout_ff[w][WORD_BITS-1:SIZE_V2_BITS];
            end
            VERSION_3: begin
               start_w = PAGE_BITS'(start_ff[w][START_LONG_BITS-1:0]);
               size_w  = PAGE_BITS'(size_ff[w][SIZE_V3_BITS-1:0]);
               on_w    = |layout_ff[w];
            end
            default: ;
         endcase
      end

      assign limit_w = {1'b0, start_w} + {1'b0, size_w};
      assign hit[w]  = on_w && (page >= start_w) && ({1'b0, page} < limit_w);
   end

   // Form the result of the popped operation
   always_comb begin
      rsp_in = '0;
      case (q_entry.op)
         OP_READ: begin
            rsp_in.read_data = read_word;
         end
         OP_CHECK: begin
            rsp_in.access_allowed = |hit;
            rsp_in.page_address   = q_entry.page_address;
         end
         default: ;
      endcase
   end

   // Result register: load on pop, clear once the transfer completes
   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(pop && rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      pop && q_entry.op == OP_WRITE |=> rsp_valid_ff && rsp_ff == '0)
      else $error("write produced non-zero result");

   a_no_layout_deny: assert property (@(posedge clock) disable iff (reset)
      pop && q_entry.op == OP_CHECK && version_ff == VERSION_NONE
      |=> !rsp_ff.access_allowed)
      else $error("check allowed without a layout");

   a_exclusive_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.access_allowed || rsp_ff.page_address != '0)
      |-> rsp_ff.read_data == '0)
      else $error("read data mixed with check result");
`endif

endmodule
`default_nettype wire

// ----- sv/dma_region_permission_filter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dma_region_permission_filter: DMA window permission check
// Register file of sixteen address windows and an identity-mapped page check.
// ----------------------------------------------------------------------------
// One request is taken per clock while the four-entry queue has room. The
// back stage takes it from the queue once the result register is free or
// being drained, and loads its result into the result register, which offers
// it to the receiver. With the receiver not stalling, the sustained rate
// is one item per cycle. That rate is set by the back stage, which stores
// or reads a word, or compares the page against all windows in parallel
// (one add and two compares per window) for each popped entry.
// Register words are cleared by reset at once. The layout version takes
// effect on the next check after it is written.
// ----------------------------------------------------------------------------
module dma_region_permission_filter
   import drpf_pkg::*;
#(
   parameter int NUM_WINDOWS = DEF_NUM_WINDOWS,
   parameter int REG_WORDS   = DEF_REG_WORDS,
   parameter int VA_BITS     = DEF_VA_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire req_type                 req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output rsp_type                      rsp_data,
   input  wire logic                    csr_write_enable,
   input  wire logic [VERSION_BITS-1:0] csr_write_data
);

   q_status_type q_status;
   logic         push;
   logic         pop;
   entry_type    push_entry;
   entry_type    pop_entry;

   // Intake and classification
   drpf_front #(
      .REG_WORDS (REG_WORDS),
      .VA_BITS   (VA_BITS)
   ) u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   // Decoupling queue
   drpf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   // Execution and result
   drpf_back #(
      .NUM_WINDOWS (NUM_WINDOWS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_entry          (pop_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

endmodule
`default_nettype wire
